// ----- rtl/core/psd_pkg.sv -----
// psd_pkg: shared constants, command codes and controller/datapath structs
// used by every module of the smallest-divisor block but psd_ram
`default_nettype none
package psd_pkg;

   localparam int N_W        = 50;
   localparam int RANK_W     = 30;
   localparam int ROOT_W     = 25;
   localparam int TRIAL_W    = ROOT_W + 1;
   localparam int STORE_DEPTH = 16384;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int DIV_CNT_W  = $clog2(N_W + 1);

   localparam logic [N_W-1:0]    N_LIMIT    = N_W'(64'd1000000000000000);
   localparam logic [RANK_W-1:0] RANK_LIMIT = RANK_W'(32'd1000000000);

   localparam logic [3:0] CMD_NONE      = 4'd0;
   localparam logic [3:0] CMD_LOAD      = 4'd1;
   localparam logic [3:0] CMD_ROOT_MUL  = 4'd2;
   localparam logic [3:0] CMD_ROOT_CMP  = 4'd3;
   localparam logic [3:0] CMD_TRY_START = 4'd4;
   localparam logic [3:0] CMD_TRY_STORE = 4'd5;
   localparam logic [3:0] CMD_READ_LAST = 4'd6;
   localparam logic [3:0] CMD_LAST_MUL  = 4'd7;
   localparam logic [3:0] CMD_LAST_CMP  = 4'd8;
   localparam logic [3:0] CMD_PICK_READ = 4'd9;
   localparam logic [3:0] CMD_QUOT_START = 4'd10;
   localparam logic [3:0] CMD_RES_SMALL = 4'd11;
   localparam logic [3:0] CMD_RES_QUOT  = 4'd12;
   localparam logic [3:0] CMD_RES_ZERO  = 4'd13;

   typedef struct packed {
      logic [3:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic invalid;
      logic root_last;
      logic trial_last;
      logic div_done;
      logic overflow;
      logic rank_small;
      logic rank_large;
      logic pick_zero;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/pth_smallest_divisor.sv -----
// pth_smallest_divisor: returns the rank-th smallest divisor of a number
// top level; depends on psd_pkg, psd_ctrl and psd_datapath
//
// One request carries n (valid 1..10^15) and a one-based rank (valid
// 1..10^9); one response returns that divisor with found set, or zero with
// found clear when n has fewer divisors or either input is out of range. The
// block handles one request at a time. It first finds isqrt(n) bit by bit, then
// tries every d from 1 to isqrt(n) on a shared restoring divider. Small
// divisors go into a 16384-entry store; large divisors are read back as n
// divided by a stored small divisor, which costs one more divider pass.
// An out-of-range request is answered from the range check alone.
`default_nettype none
module pth_smallest_divisor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // n_value [49:0], rank [79:50]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // divisor [49:0], zero pad [55:50]
   output logic             rsp_tuser    // found
);
   psd_pkg::dp_cmd_type    cmd;
   psd_pkg::dp_status_type status;
   logic                   idle;
   logic [psd_pkg::N_W-1:0] divisor;
   logic                   found;

   // a request is taken only while the controller is idle: none in work, no response pending
   assign req_tready = idle;

   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_tvalid && idle),
      .rsp_taken (rsp_tready),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle),
      .rsp_valid (rsp_tvalid)
   );

   psd_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .n_value (req_tdata[49:0]),
      .rank    (req_tdata[79:50]),
      .status  (status),
      .divisor (divisor),
      .found   (found)
   );

   assign rsp_tdata = {6'd0, divisor};
   assign rsp_tuser = found;
endmodule
`default_nettype wire

// ----- rtl/core/psd_ram.sv -----
// psd_ram: generic single-port-write, registered-read memory
// no dependencies
`default_nettype none
module psd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/psd_div.sv -----
// psd_div: restoring divider, one quotient bit per cycle
// depends on psd_pkg
`default_nettype none
module psd_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [psd_pkg::N_W-1:0]       dividend,
   input  wire logic [psd_pkg::TRIAL_W-1:0]   divisor,
   output logic      [psd_pkg::N_W-1:0]       quotient,
   output logic      [psd_pkg::TRIAL_W-1:0]   remainder,
   output logic                               done
);
   logic [psd_pkg::N_W-1:0]       quo_ff, quo_in;
   logic [psd_pkg::TRIAL_W-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [psd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [psd_pkg::TRIAL_W:0]     trial;
   logic                          fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[psd_pkg::N_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[psd_pkg::N_W-2:0], fits};
         rem_in = fits ? psd_pkg::TRIAL_W'(trial - {1'b0, dvs_ff})
                       : psd_pkg::TRIAL_W'(trial);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == psd_pkg::DIV_CNT_W'(psd_pkg::N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule
`default_nettype wire

// ----- rtl/core/psd_datapath.sv -----
// psd_datapath: operand registers, square-root and trial registers, divisor store
// depends on psd_pkg, psd_div and psd_ram
`default_nettype none
module psd_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire psd_pkg::dp_cmd_type         cmd,
   input  wire logic [psd_pkg::N_W-1:0]     n_value,
   input  wire logic [psd_pkg::RANK_W-1:0]  rank,
   output psd_pkg::dp_status_type           status,
   output logic      [psd_pkg::N_W-1:0]     divisor,
   output logic                             found
);
   logic [psd_pkg::N_W-1:0]     n_ff, n_in;
   logic [psd_pkg::RANK_W-1:0]  rank_ff, rank_in;
   logic [psd_pkg::ROOT_W-1:0]  root_ff, root_in, cand;
   logic [4:0]                  bit_ff, bit_in;
   logic [psd_pkg::N_W-1:0]     prod_ff, prod_in;
   logic [psd_pkg::TRIAL_W-1:0] d_ff, d_in;
   logic [psd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        ovf_ff, ovf_in, sq_ff, sq_in;
   logic [psd_pkg::N_W-1:0]     res_ff, res_in;
   logic                        found_ff, found_in;

   logic                        div_start, div_done;
   logic [psd_pkg::TRIAL_W-1:0] div_dvs, div_rem;
   logic [psd_pkg::N_W-1:0]     div_quo;

   logic                        wr_en;
   logic [psd_pkg::ADDR_W-1:0]  rd_addr;
   logic [psd_pkg::N_W-1:0]     rd_data;
   logic [psd_pkg::RANK_W:0]    total, large_idx;

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (div_dvs),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   psd_ram #(.WIDTH(psd_pkg::N_W), .DEPTH(psd_pkg::STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[psd_pkg::ADDR_W-1:0]),
      .wr_data (psd_pkg::N_W'(d_ff)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // divisor list length: small ones twice, less the square root if exact
   assign total     = (psd_pkg::RANK_W+1)'({cnt_ff, 1'b0}) - (psd_pkg::RANK_W+1)'(sq_ff);
   assign large_idx = total - (psd_pkg::RANK_W+1)'(rank_ff);
   assign cand      = root_ff | (psd_pkg::ROOT_W'(1) << bit_ff);

   always_comb begin
      n_in     = n_ff;
      rank_in  = rank_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      prod_in  = prod_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      sq_in    = sq_ff;
      res_in   = res_ff;
      found_in = found_ff;
      wr_en    = 1'b0;
      div_start = 1'b0;
      div_dvs  = d_ff;
      rd_addr  = '0;
      unique case (cmd.op)
         psd_pkg::CMD_LOAD: begin
            n_in    = n_value;
            rank_in = rank;
            root_in = '0;
            bit_in  = 5'(psd_pkg::ROOT_W - 1);
            d_in    = psd_pkg::TRIAL_W'(1);
            cnt_in  = '0;
            ovf_in  = 1'b0;
         end
         psd_pkg::CMD_ROOT_MUL: begin
            prod_in = psd_pkg::N_W'(cand * cand);
         end
         psd_pkg::CMD_ROOT_CMP: begin
            if (prod_ff <= n_ff) begin
               root_in = cand;
            end
            bit_in = bit_ff - 1'b1;
         end
         psd_pkg::CMD_TRY_START: begin
            div_start = 1'b1;
         end
         psd_pkg::CMD_TRY_STORE: begin
            if (div_rem == '0) begin
               if (cnt_ff < psd_pkg::CNT_W'(psd_pkg::STORE_DEPTH)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            d_in = d_ff + 1'b1;
         end
         psd_pkg::CMD_READ_LAST: begin
            rd_addr = psd_pkg::ADDR_W'(cnt_ff - 1'b1);
         end
         psd_pkg::CMD_LAST_MUL: begin
            prod_in = psd_pkg::N_W'(rd_data[psd_pkg::ROOT_W-1:0] * rd_data[psd_pkg::ROOT_W-1:0]);
         end
         psd_pkg::CMD_LAST_CMP: begin
            sq_in = prod_ff == n_ff;
         end
         psd_pkg::CMD_PICK_READ: begin
            if (status.rank_small) begin
               rd_addr = psd_pkg::ADDR_W'(rank_ff - 1'b1);
            end else begin
               rd_addr = large_idx[psd_pkg::ADDR_W-1:0];
            end
         end
         psd_pkg::CMD_QUOT_START: begin
            div_start = 1'b1;
            div_dvs   = rd_data[psd_pkg::TRIAL_W-1:0];
         end
         psd_pkg::CMD_RES_SMALL: begin
            res_in   = rd_data;
            found_in = 1'b1;
         end
         psd_pkg::CMD_RES_QUOT: begin
            res_in   = div_quo;
            found_in = 1'b1;
         end
         psd_pkg::CMD_RES_ZERO: begin
            res_in   = '0;
            found_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         root_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         root_ff <= root_in;
         ovf_ff  <= ovf_in;
      end
      n_ff     <= n_in;
      rank_ff  <= rank_in;
      bit_ff   <= bit_in;
      prod_ff  <= prod_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      res_ff   <= res_in;
      found_ff <= found_in;
   end

   always_comb begin
      status.invalid    = (n_ff == '0) || (n_ff > psd_pkg::N_LIMIT) ||
                          (rank_ff == '0) || (rank_ff > psd_pkg::RANK_LIMIT);
      status.root_last  = bit_ff == '0;
      status.trial_last = d_ff == psd_pkg::TRIAL_W'(root_ff);
      status.div_done   = div_done;
      status.overflow   = ovf_ff;
      status.rank_small = rank_ff <= psd_pkg::RANK_W'(cnt_ff);
      status.rank_large = (psd_pkg::RANK_W+1)'(rank_ff) <= total;
      status.pick_zero  = rd_data == '0;
   end

   assign divisor = res_ff;
   assign found   = found_ff;
endmodule
`default_nettype wire

// ----- rtl/core/psd_ctrl.sv -----
// psd_ctrl: sequencing state machine for the smallest-divisor block
// depends on psd_pkg
`default_nettype none
module psd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_fire,
   input  wire logic                  rsp_taken,
   input  wire psd_pkg::dp_status_type status,
   output psd_pkg::dp_cmd_type        cmd,
   output logic                       idle,
   output logic                       rsp_valid
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_RMUL   = 4'd2;
   localparam logic [3:0] S_RCMP   = 4'd3;
   localparam logic [3:0] S_TSTART = 4'd4;
   localparam logic [3:0] S_TWAIT  = 4'd5;
   localparam logic [3:0] S_LREAD  = 4'd6;
   localparam logic [3:0] S_LMUL   = 4'd7;
   localparam logic [3:0] S_LCMP   = 4'd8;
   localparam logic [3:0] S_DECIDE = 4'd9;
   localparam logic [3:0] S_PREAD  = 4'd10;
   localparam logic [3:0] S_PDATA  = 4'd11;
   localparam logic [3:0] S_QWAIT  = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = psd_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.op   = psd_pkg::CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.invalid) begin
               cmd.op   = psd_pkg::CMD_RES_ZERO;
               state_in = S_DONE;
            end else begin
               state_in = S_RMUL;
            end
         end
         S_RMUL: begin
            cmd.op   = psd_pkg::CMD_ROOT_MUL;
            state_in = S_RCMP;
         end
         S_RCMP: begin
            cmd.op   = psd_pkg::CMD_ROOT_CMP;
            state_in = status.root_last ? S_TSTART : S_RMUL;
         end
         S_TSTART: begin
            cmd.op   = psd_pkg::CMD_TRY_START;
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            if (status.div_done) begin
               cmd.op   = psd_pkg::CMD_TRY_STORE;
               state_in = status.trial_last ? S_LREAD : S_TSTART;
            end
         end
         S_LREAD: begin
            cmd.op   = psd_pkg::CMD_READ_LAST;
            state_in = S_LMUL;
         end
         S_LMUL: begin
            cmd.op   = psd_pkg::CMD_LAST_MUL;
            state_in = S_LCMP;
         end
         S_LCMP: begin
            cmd.op   = psd_pkg::CMD_LAST_CMP;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.overflow || !status.rank_large) begin
               cmd.op   = psd_pkg::CMD_RES_ZERO;
               state_in = S_DONE;
            end else begin
               state_in = S_PREAD;
            end
         end
         S_PREAD: begin
            cmd.op   = psd_pkg::CMD_PICK_READ;
            state_in = S_PDATA;
         end
         S_PDATA: begin
            if (status.rank_small) begin
               cmd.op   = psd_pkg::CMD_RES_SMALL;
               state_in = S_DONE;
            end else if (status.pick_zero) begin
               cmd.op   = psd_pkg::CMD_RES_ZERO;
               state_in = S_DONE;
            end else begin
               cmd.op   = psd_pkg::CMD_QUOT_START;
               state_in = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (status.div_done) begin
               cmd.op   = psd_pkg::CMD_RES_QUOT;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle      = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_DONE;
endmodule
`default_nettype wire
